### src/hash_multiset_intersection_macros.svh
// assertion macros for the hash multiset intersection block
`ifndef HASH_MULTISET_INTERSECTION_MACROS_SVH
`define HASH_MULTISET_INTERSECTION_MACROS_SVH
`ifndef SYNTH
`define HMI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define HMI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define HMI_ASSERT(lbl, clk, rst, prop, msg)
`define HMI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### src/hmi_pkg.sv
// types and constants of the hash multiset intersection block
`timescale 1ns / 1ps
package hmi_pkg;
  localparam int BUCKETS = 1024;
  localparam int ENTRIES = 1024;
  localparam int BKT_W = 10;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_PROBE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] value;
    logic               last_of_set;
  } hmi_req_t;

  typedef struct packed {
    logic signed [31:0] echo_value;
    logic               matched;
    logic [CNT_W-1:0]   count_after;
    logic               status;
  } hmi_res_t;

  typedef struct packed {
    hmi_req_t         item;
    logic [BKT_W-1:0] bucket;
  } hmi_job_t;

  typedef struct packed {
    logic [31:0]      key;
    logic [CNT_W-1:0] count;
    logic             nvalid;
    logic [IDX_W-1:0] next;
  } hmi_node_t;

  typedef struct packed {
    logic             hvalid;
    logic [IDX_W-1:0] idx;
  } hmi_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } hmi_ctl_t;
endpackage

### src/hmi_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module hmi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/hmi_front.sv
// request intake: bucket selection and a two-entry job queue
`timescale 1ns / 1ps
module hmi_front import hmi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  hmi_req_t req,
  input  hmi_ctl_t ctl,
  output logic     job_valid,
  output hmi_job_t job
);
  logic [31:0] mag;
  hmi_job_t    q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  cnt;
  logic        push;
  logic        pop;

  // magnitude of the signed value, then bucket by low bits
  assign mag = req.value[31] ? (32'd0 - req.value) : req.value;
  assign busy = (cnt == 2'd2) || ctl.clearing;
  assign push = start && !busy;
  assign pop = ctl.pop && (cnt != 2'd0);
  assign job_valid = (cnt != 2'd0);
  assign job = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].item <= req;
      q[wr_ptr].bucket <= mag[BKT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end
endmodule

### src/hmi_back.sv
// table engine: chain walk, count update, node allocation and clearing pass
`timescale 1ns / 1ps
`include "hash_multiset_intersection_macros.svh"
module hmi_back import hmi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     job_valid,
  input  hmi_job_t job,
  output hmi_ctl_t ctl,
  output logic     done,
  output hmi_res_t res
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HEAD  = 5'b00010,
    S_NODE  = 5'b00100,
    S_DONE  = 5'b01000,
    S_CLEAR = 5'b10000
  } state_t;

  state_t           state;
  hmi_job_t         cur;
  logic [IDX_W-1:0] cur_idx;
  hmi_head_t        hsave;
  hmi_node_t        fnode;
  logic             fnd;
  logic [CNT_W-1:0] nodes_used;
  logic [CNT_W-1:0] clr_cnt;

  hmi_head_t        head_rd;
  hmi_head_t        head_wd;
  logic             head_we;
  logic [BKT_W-1:0] head_waddr;
  hmi_node_t        node_rd;
  hmi_node_t        node_wd;
  logic             node_we;
  logic [IDX_W-1:0] node_waddr;
  logic [IDX_W-1:0] node_raddr;

  logic [CNT_W-1:0] cnt_next;
  logic             matched_next;
  logic             status_next;
  logic             alloc;

  hmi_ram #(.WIDTH($bits(hmi_head_t)), .DEPTH(BUCKETS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wd),
    .raddr(job.bucket), .rdata(head_rd)
  );

  hmi_ram #(.WIDTH($bits(hmi_node_t)), .DEPTH(ENTRIES)) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wd),
    .raddr(node_raddr), .rdata(node_rd)
  );

  assign ctl.pop = (state == S_IDLE) && job_valid;
  assign ctl.clearing = (state == S_CLEAR);
  assign node_raddr = (state == S_HEAD) ? head_rd.idx : node_rd.next;

  always_comb begin
    cnt_next = '0;
    matched_next = 1'b0;
    status_next = 1'b0;
    alloc = 1'b0;
    if (cur.item.mode == MODE_INSERT) begin
      if (fnd) begin
        cnt_next = (fnode.count < COUNT_MAX) ? fnode.count + 11'd1 : fnode.count;
      end else if (nodes_used < CNT_W'(ENTRIES)) begin
        cnt_next = 11'd1;
        alloc = 1'b1;
      end else begin
        status_next = 1'b1;
      end
    end else if (fnd && (fnode.count != '0)) begin
      cnt_next = fnode.count - 11'd1;
      matched_next = 1'b1;
    end
  end

  always_comb begin
    node_we = 1'b0;
    node_waddr = fnd ? cur_idx : nodes_used[IDX_W-1:0];
    node_wd = fnode;
    head_we = 1'b0;
    head_waddr = cur.bucket;
    head_wd.hvalid = 1'b1;
    head_wd.idx = nodes_used[IDX_W-1:0];
    if (state == S_DONE) begin
      if (fnd) begin
        node_we = (cur.item.mode == MODE_INSERT) || matched_next;
        node_wd.count = cnt_next;
      end else if (alloc) begin
        node_we = 1'b1;
        node_wd.key = cur.item.value;
        node_wd.count = cnt_next;
        node_wd.nvalid = hsave.hvalid;
        node_wd.next = hsave.idx;
        head_we = 1'b1;
      end
    end else if (state == S_CLEAR) begin
      head_we = 1'b1;
      head_waddr = clr_cnt[BKT_W-1:0];
      head_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: cur <= job;
      S_HEAD: begin
        hsave <= head_rd;
        cur_idx <= head_rd.idx;
        fnd <= 1'b0;
      end
      S_NODE: begin
        if (node_rd.key == cur.item.value) begin
          fnd <= 1'b1;
          fnode <= node_rd;
        end else begin
          cur_idx <= node_rd.next;
        end
      end
      S_DONE: begin
        res.echo_value <= cur.item.value;
        res.matched <= matched_next;
        res.count_after <= cnt_next;
        res.status <= status_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      nodes_used <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      unique case (state)
        S_IDLE: if (job_valid) state <= S_HEAD;
        S_HEAD: state <= head_rd.hvalid ? S_NODE : S_DONE;
        S_NODE: begin
          if ((node_rd.key == cur.item.value) || !node_rd.nvalid) state <= S_DONE;
        end
        S_DONE: begin
          if (alloc) nodes_used <= nodes_used + 11'd1;
          if ((cur.item.mode == MODE_PROBE) && cur.item.last_of_set) begin
            nodes_used <= '0;
            clr_cnt <= '0;
            state <= S_CLEAR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 11'd1;
          if (clr_cnt == CNT_W'(BUCKETS - 1)) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  `HMI_ASSERT_IMP(a_done_after_finish, clk, rst, done, $past(state == S_DONE), "result strobe without finished request")
  `HMI_ASSERT(a_pool_bound, clk, rst, nodes_used <= CNT_W'(ENTRIES), "node pool count out of range")
  `HMI_ASSERT_IMP(a_quiet_clear, clk, rst, (state == S_CLEAR) && (clr_cnt != '0), !done && !ctl.pop, "activity during clearing pass")
endmodule

### src/hash_multiset_intersection.sv
// top level of the hash multiset intersection block
`timescale 1ns / 1ps
// Counting hash table over signed 32-bit values: a request with mode insert
// adds a value, one with mode probe takes one copy of it out and reports a
// match. Requests are taken when start is high and busy is low; two may wait
// in the intake queue. Each request yields one result, shown for exactly one
// cycle with done high; it cannot be held off. A request reads the bucket
// head, then one chain node per step through the registered node memory,
// then writes its result. After reset and after a probe marked last, busy
// stays high during a pass that empties the bucket heads.
module hash_multiset_intersection import hmi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  hmi_req_t req,
  output logic     done,
  output hmi_res_t res
);
  hmi_ctl_t ctl;
  hmi_job_t job;
  logic     job_valid;

  hmi_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .ctl(ctl), .job_valid(job_valid), .job(job)
  );

  hmi_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job),
    .ctl(ctl), .done(done), .res(res)
  );
endmodule

### test/tb_hash_multiset_intersection.sv
// testbench for the hash multiset intersection block
`timescale 1ns / 1ps
module tb_hash_multiset_intersection;
  import hmi_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  hmi_req_t req = '0;
  logic     done;
  hmi_res_t res;

  hash_multiset_intersection dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .res(res)
  );

  always #5 clk = ~clk;

  // model of the table: one count per stored value, plus the number of pool entries in use
  int unsigned tally[logic [31:0]];
  int unsigned pool_used;
  hmi_res_t    expected_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          max_gap = 6;

  function automatic hmi_res_t predict_result(hmi_req_t r);
    hmi_res_t    o;
    logic [31:0] k;
    k = r.value;
    o = '0;
    o.echo_value = r.value;
    if (r.mode == MODE_INSERT) begin
      if (tally.exists(k)) begin
        if (tally[k] < COUNT_MAX) tally[k]++;
        o.count_after = CNT_W'(tally[k]);
      end else if (pool_used < ENTRIES) begin
        tally[k] = 1;
        pool_used++;
        o.count_after = CNT_W'(1);
      end else begin
        o.status = 1'b1;
      end
    end else begin
      if (tally.exists(k) && tally[k] > 0) begin
        tally[k]--;
        o.matched = 1'b1;
        o.count_after = CNT_W'(tally[k]);
      end
      if (r.last_of_set) begin
        tally.delete();
        pool_used = 0;
      end
    end
    return o;
  endfunction

  // start stays high between back to back requests
  task automatic send_request(logic m, logic [31:0] v, logic l);
    hmi_req_t r;
    int       gap;
    r.mode = m;
    r.value = v;
    r.last_of_set = l;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_result(r));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: %p", $time, res);
          errors++;
        end else begin
          hmi_res_t e;
          e = expected_q.pop_front();
          if (res.echo_value !== e.echo_value || res.matched !== e.matched ||
              res.count_after !== e.count_after || res.status !== e.status) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, res);
            errors++;
          end
        end
      end
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("tb_hash_multiset_intersection: errors");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_value(int unsigned span);
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      3: return -$urandom_range(0, span);
      // buckets 0 to 3, several different values in each
      4: return $urandom_range(0, 7) * BUCKETS + $urandom_range(0, 3);
      default: return $urandom_range(0, span);
    endcase
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(MODE_PROBE, 32'd5, 1'b0);           // probe of absent value
    send_request(MODE_INSERT, 32'h8000_0000, 1'b1);  // last mark on insert ignored
    send_request(MODE_INSERT, 32'h7fff_ffff, 1'b0);
    send_request(MODE_INSERT, 32'hffff_ffff, 1'b0);
    send_request(MODE_INSERT, 32'd1, 1'b0);          // same bucket as -1
    send_request(MODE_INSERT, 32'd1025, 1'b0);
    send_request(MODE_INSERT, 32'd0, 1'b0);
    send_request(MODE_INSERT, 32'd1, 1'b0);
    send_request(MODE_PROBE, 32'd1, 1'b0);
    send_request(MODE_PROBE, 32'd1, 1'b0);
    send_request(MODE_PROBE, 32'd1, 1'b0);           // count already zero
    send_request(MODE_PROBE, 32'hffff_ffff, 1'b0);
    send_request(MODE_PROBE, 32'h8000_0000, 1'b0);
    send_request(MODE_PROBE, 32'h7fff_ffff, 1'b1);   // clears the table
    send_request(MODE_PROBE, 32'd0, 1'b0);
    send_request(MODE_PROBE, 32'd0, 1'b1);
  endtask

  // fill the pool, then refuse new values while repeats still count
  task automatic test_pool_full();
    max_gap = 0;
    for (int i = 0; i < ENTRIES; i++) send_request(MODE_INSERT, i * 3 - 1500, 1'b0);
    send_request(MODE_INSERT, 32'h1234_5678, 1'b0);
    send_request(MODE_INSERT, -32'sd1500, 1'b0);
    send_request(MODE_PROBE, 32'h1234_5678, 1'b0);
    send_request(MODE_PROBE, -32'sd1497, 1'b1);
    max_gap = 6;
  endtask

  // sets of random content: load phase then probe phase ending with last
  task automatic test_random_sets();
    int total;
    int n;
    int unsigned span;
    total = 0;
    while (total < 300) begin
      n = $urandom_range(1, 40);
      span = ($urandom_range(0, 1)) ? 30 : 3000;
      if ($urandom_range(0, 3) == 0) max_gap = 0;
      else max_gap = 6;
      for (int i = 0; i < n; i++)
        send_request($urandom_range(0, 9) == 0, pick_value(span), 1'($urandom_range(0, 1)));
      for (int i = 0; i < n; i++)
        send_request(MODE_PROBE, pick_value(span), $urandom_range(0, 15) == 0);
      send_request(MODE_PROBE, pick_value(span), 1'b1);
      total += 2 * n + 1;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_pool_full();
    test_random_sets();
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_hash_multiset_intersection: clean");
    end else begin
      $display("tb_hash_multiset_intersection: errors");
    end
    $finish;
  end
endmodule
